>>> hdl/hrp_pkg.sv
// Shared types, character codes and helper functions for the HTTP response parser.
`timescale 1ns / 1ps

package hrp_pkg;

    // Default limits on stored header name and value bytes.
    localparam int NameMaxDefault  = 128;
    localparam int ValueMaxDefault = 128;

    // Length of the header name that carries the body length.
    localparam int KeyLen = 14;

    // Character codes used by the parser.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Result kinds.
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_HDR_DONE  = 3'd1;
    localparam logic [2:0] KIND_BODY      = 3'd2;
    localparam logic [2:0] KIND_BODY_LAST = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_VERSION = 8'b0000_0001,
        PH_CODE    = 8'b0000_0010,
        PH_REASON  = 8'b0000_0100,
        PH_LINE    = 8'b0000_1000,
        PH_NAME    = 8'b0001_0000,
        PH_VALUE   = 8'b0010_0000,
        PH_BODY    = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    // One input request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_response;
    } t_in_req;

    // One result.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  body_byte;
        logic [15:0] status_code;
        logic [31:0] content_length;
    } t_out_res;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_OFFSET : c;
    endfunction

    // Lower-case "content-length", one character per index.
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            4'd0:  c = 8'h63; // c
            4'd1:  c = 8'h6F; // o
            4'd2:  c = 8'h6E; // n
            4'd3:  c = 8'h74; // t
            4'd4:  c = 8'h65; // e
            4'd5:  c = 8'h6E; // n
            4'd6:  c = 8'h74; // t
            4'd7:  c = 8'h2D; // -
            4'd8:  c = 8'h6C; // l
            4'd9:  c = 8'h65; // e
            4'd10: c = 8'h6E; // n
            4'd11: c = 8'h67; // g
            4'd12: c = 8'h74; // t
            4'd13: c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/http_response_header_parser.sv
// Top level of the HTTP response header parser.
// The block takes an HTTP response one byte per request on the input channel
// (valid/ready) and returns exactly one result per byte on the output channel.
// Each result carries the byte kind (header byte, headers done, body byte,
// last body byte, error after finish), the body byte itself, and the status
// code and content length parsed so far.
// Setting new_response on a byte clears all parser state so that the byte
// starts a new response.
// A byte accepted on the input is captured in the input register, and its
// result is then registered in the result register. Throughput is one byte
// per cycle while the receiver takes results; each byte needs only a short
// update of the parser state between the input and result registers.
// Reset clears the parser state and empties both register stages.
// When the receiver stalls, the result register holds its result, the input
// register holds its byte or, if empty, takes one further byte, and input
// ready then stays low until the result is taken.
`timescale 1ns / 1ps

module http_response_header_parser #(
    parameter int NAME_MAX  = hrp_pkg::NameMaxDefault,
    parameter int VALUE_MAX = hrp_pkg::ValueMaxDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hrp_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hrp_pkg::t_out_res o_out_res
);

    logic             s_valid;
    logic             s_ready;
    hrp_pkg::t_in_req s_req;

    // Input register.
    hrp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_s_valid  (s_valid),
        .i_s_ready  (s_ready),
        .o_s_req    (s_req)
    );

    // Parser and result register.
    hrp_core #(
        .NAME_MAX  (NAME_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_valid),
        .o_s_ready   (s_ready),
        .i_s_req     (s_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

endmodule

>>> hdl/hrp_in_stage.sv
// Input register stage of the HTTP response parser.
`timescale 1ns / 1ps

module hrp_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hrp_pkg::t_in_req i_in_req,
    output logic             o_s_valid,
    input  logic             i_s_ready,
    output hrp_pkg::t_in_req o_s_req
);

    logic             r_valid;
    hrp_pkg::t_in_req r_req;

    // The stage can take a request when it is empty or is being emptied.
    assign o_in_ready = !r_valid || i_s_ready;
    assign o_s_valid  = r_valid;
    assign o_s_req    = r_req;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Request payload.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req <= i_in_req;
        end
    end

endmodule

>>> hdl/hrp_core.sv
// Parser state, per-byte update logic and result register.
`timescale 1ns / 1ps

module hrp_core #(
    parameter int NAME_MAX  = hrp_pkg::NameMaxDefault,
    parameter int VALUE_MAX = hrp_pkg::ValueMaxDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  hrp_pkg::t_in_req  i_s_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hrp_pkg::t_out_res o_out_res
);

    localparam int NW = $clog2(NAME_MAX + 1);
    localparam int VW = $clog2(VALUE_MAX);

    // Parser state.
    hrp_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_status_accum, n_status_accum;
    logic [15:0]     r_status_value, n_status_value;
    logic [NW-1:0]   r_name_len, n_name_len;
    logic            r_name_ok, n_name_ok;
    logic [VW-1:0]   r_value_len, n_value_len;
    logic [31:0]     r_value_accum, n_value_accum;
    logic            r_value_done, n_value_done;
    logic            r_line_text, n_line_text;
    logic [31:0]     r_length_value, n_length_value;
    logic [31:0]     r_body_count, n_body_count;

    // Result register.
    logic              r_out_valid;
    hrp_pkg::t_out_res r_out, n_out;

    logic       step;
    logic [7:0] b;
    logic [3:0] digit;
    logic [19:0] status_wide;
    logic [35:0] value_wide;
    logic [31:0] body_next;

    // Effective state once a new-response request has cleared it.
    hrp_pkg::t_phase c_phase;
    logic [15:0]     c_status_accum;
    logic [15:0]     c_status_value;
    logic [NW-1:0]   c_name_len;
    logic            c_name_ok;
    logic [VW-1:0]   c_value_len;
    logic [31:0]     c_value_accum;
    logic            c_value_done;
    logic            c_line_text;
    logic [31:0]     c_length_value;
    logic [31:0]     c_body_count;

    // Name bytes are handled either in the name phase or on the first byte of a line.
    logic            do_name;
    logic [NW-1:0]   nm_len;
    logic            nm_ok;

    assign o_s_ready   = !r_out_valid || i_out_ready;
    assign step        = i_s_valid && o_s_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    assign b     = i_s_req.data_byte;
    assign digit = b[3:0] - hrp_pkg::CH_ZERO[3:0];

    // Clear on a new response.
    always_comb begin
        if (i_s_req.new_response) begin
            c_phase        = hrp_pkg::PH_VERSION;
            c_status_accum = '0;
            c_status_value = '0;
            c_name_len     = '0;
            c_name_ok      = 1'b1;
            c_value_len    = '0;
            c_value_accum  = '0;
            c_value_done   = 1'b0;
            c_line_text    = 1'b0;
            c_length_value = '0;
            c_body_count   = '0;
        end else begin
            c_phase        = r_phase;
            c_status_accum = r_status_accum;
            c_status_value = r_status_value;
            c_name_len     = r_name_len;
            c_name_ok      = r_name_ok;
            c_value_len    = r_value_len;
            c_value_accum  = r_value_accum;
            c_value_done   = r_value_done;
            c_line_text    = r_line_text;
            c_length_value = r_length_value;
            c_body_count   = r_body_count;
        end
    end

    // Times-ten accumulations by shift and add.
    assign status_wide = {1'b0, c_status_accum, 3'b000} + {3'b000, c_status_accum, 1'b0}
                         + {16'd0, digit};
    assign value_wide  = {1'b0, c_value_accum, 3'b000} + {3'b000, c_value_accum, 1'b0}
                         + {32'd0, digit};
    assign body_next   = c_body_count + 32'd1;

    // Per-byte state update.
    always_comb begin
        n_phase        = c_phase;
        n_status_accum = c_status_accum;
        n_status_value = c_status_value;
        n_name_len     = c_name_len;
        n_name_ok      = c_name_ok;
        n_value_len    = c_value_len;
        n_value_accum  = c_value_accum;
        n_value_done   = c_value_done;
        n_line_text    = c_line_text;
        n_length_value = c_length_value;
        n_body_count   = c_body_count;
        n_out.kind     = hrp_pkg::KIND_HEADER;
        n_out.body_byte = 8'h00;
        do_name        = 1'b0;
        nm_len         = c_name_len;
        nm_ok          = c_name_ok;

        unique case (c_phase)
            hrp_pkg::PH_VERSION: begin
                if (b == hrp_pkg::CH_SPACE) begin
                    n_phase = hrp_pkg::PH_CODE;
                end
            end
            hrp_pkg::PH_CODE: begin
                if (b == hrp_pkg::CH_SPACE) begin
                    n_status_value = c_status_accum;
                    n_phase        = hrp_pkg::PH_REASON;
                end else if (hrp_pkg::is_digit(b)) begin
                    n_status_accum = (status_wide[19:16] != 4'd0) ? 16'hFFFF
                                                                  : status_wide[15:0];
                end
            end
            hrp_pkg::PH_REASON: begin
                if (b == hrp_pkg::CH_LF) begin
                    n_phase = hrp_pkg::PH_LINE;
                end
            end
            hrp_pkg::PH_VALUE: begin
                if (b == hrp_pkg::CH_CR || b == hrp_pkg::CH_LF) begin
                    if (c_name_ok && c_name_len == NW'(hrp_pkg::KeyLen)) begin
                        n_length_value = c_value_accum;
                    end
                    n_phase     = hrp_pkg::PH_LINE;
                    n_line_text = (b == hrp_pkg::CH_CR);
                end else if ((c_value_len != '0 || b != hrp_pkg::CH_SPACE)
                             && c_value_len < VW'(VALUE_MAX - 1)) begin
                    n_value_len = c_value_len + VW'(1);
                    if (!c_value_done) begin
                        if (hrp_pkg::is_digit(b)) begin
                            n_value_accum = (value_wide[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                        : value_wide[31:0];
                        end else begin
                            n_value_done = 1'b1;
                        end
                    end
                end
            end
            hrp_pkg::PH_LINE: begin
                if (b == hrp_pkg::CH_LF) begin
                    if (!c_line_text) begin
                        n_out.kind = hrp_pkg::KIND_HDR_DONE;
                        n_phase    = (c_length_value == 32'd0) ? hrp_pkg::PH_DONE
                                                               : hrp_pkg::PH_BODY;
                    end
                    n_line_text = 1'b0;
                end else if (b != hrp_pkg::CH_CR) begin
                    // First byte of a new header name.
                    do_name = 1'b1;
                    nm_len  = '0;
                    nm_ok   = 1'b1;
                end
            end
            hrp_pkg::PH_NAME: begin
                do_name = 1'b1;
            end
            hrp_pkg::PH_BODY: begin
                n_out.body_byte = b;
                n_body_count    = body_next;
                if (body_next >= c_length_value) begin
                    n_out.kind = hrp_pkg::KIND_BODY_LAST;
                    n_phase    = hrp_pkg::PH_DONE;
                end else begin
                    n_out.kind = hrp_pkg::KIND_BODY;
                end
            end
            default: begin
                n_out.kind = hrp_pkg::KIND_ERROR;
            end
        endcase

        // Header name byte: compare against the key or end the name.
        if (do_name) begin
            if (b != hrp_pkg::CH_COLON && nm_len < NW'(NAME_MAX)) begin
                n_name_ok = nm_ok;
                if (nm_len >= NW'(hrp_pkg::KeyLen)
                    || hrp_pkg::to_lower(b) != hrp_pkg::key_char(nm_len[3:0])) begin
                    n_name_ok = 1'b0;
                end
                n_name_len = nm_len + NW'(1);
                n_phase    = hrp_pkg::PH_NAME;
            end else begin
                n_name_len    = nm_len;
                n_name_ok     = nm_ok;
                n_value_len   = '0;
                n_value_accum = '0;
                n_value_done  = 1'b0;
                n_line_text   = 1'b1;
                n_phase       = hrp_pkg::PH_VALUE;
            end
        end

        n_out.status_code    = n_status_value;
        n_out.content_length = n_length_value;
    end

    // Control state and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= hrp_pkg::PH_VERSION;
            r_status_accum <= '0;
            r_status_value <= '0;
            r_name_len     <= '0;
            r_name_ok      <= 1'b1;
            r_value_len    <= '0;
            r_value_accum  <= '0;
            r_value_done   <= 1'b0;
            r_line_text    <= 1'b0;
            r_length_value <= '0;
            r_body_count   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_s_ready) begin
                r_out_valid <= i_s_valid;
            end
            if (step) begin
                r_phase        <= n_phase;
                r_status_accum <= n_status_accum;
                r_status_value <= n_status_value;
                r_name_len     <= n_name_len;
                r_name_ok      <= n_name_ok;
                r_value_len    <= n_value_len;
                r_value_accum  <= n_value_accum;
                r_value_done   <= n_value_done;
                r_line_text    <= n_line_text;
                r_length_value <= n_length_value;
                r_body_count   <= n_body_count;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    // A valid result never carries an undefined kind.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.kind <= hrp_pkg::KIND_ERROR))
        else $error("result kind out of range");

    // Only body results carry a data byte.
    a_body_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != hrp_pkg::KIND_BODY
         && r_out.kind != hrp_pkg::KIND_BODY_LAST) |-> (r_out.body_byte == 8'h00))
        else $error("non-body result carries a data byte");

    // Once finished, every byte of the same response is an error.
    a_done_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !i_s_req.new_response && r_phase == hrp_pkg::PH_DONE)
        |=> (r_out.kind == hrp_pkg::KIND_ERROR))
        else $error("byte after finish not flagged");

    // While in the body, the count stays below the content length.
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hrp_pkg::PH_BODY) |-> (r_body_count < r_length_value))
        else $error("body count reached length without finishing");

endmodule
